// ===== hw/rtl/trilinear_vector_field_map_unit_defines.svh =====
// Assertion macros for the trilinear vector field map unit
`ifndef TRILINEAR_VECTOR_FIELD_MAP_UNIT_DEFINES_SVH
`define TRILINEAR_VECTOR_FIELD_MAP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TVF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TVF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TVF_ASSERT_IMP(label, clk, rst, ante, cons)
`define TVF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tvfm_pkg.sv =====
// Shared types and constants for the trilinear vector field map
package tvfm_pkg;
   localparam int NODES_X = 16;
   localparam int NODES_Y = 16;
   localparam int NODES_Z = 16;
   localparam int XW = $clog2(NODES_X);
   localparam int YW = $clog2(NODES_Y);
   localparam int ZW = $clog2(NODES_Z);
   localparam int DEPTH = NODES_X * NODES_Y * NODES_Z;
   localparam int AW = XW + YW + ZW;

   typedef enum logic [2:0] {
      CSR_X_ORIGIN = 3'd0, CSR_Y_ORIGIN = 3'd1, CSR_Z_ORIGIN = 3'd2,
      CSR_X_INV = 3'd3, CSR_Y_INV = 3'd4, CSR_Z_INV = 3'd5
   } csr_index_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [31:0] comp_type;
   typedef comp_type [2:0] vec_type;

   // cell location of one axis
   typedef struct packed {
      logic        ok;
      logic [7:0]  idx;
      logic [15:0] frac;
   } loc_type;

   // one lerp step: a + round((b-a)*f / 65536), saturated
   function automatic comp_type lerp(comp_type a, comp_type b, logic [15:0] f);
      logic signed [32:0] d;
      logic signed [50:0] t;
      logic signed [34:0] q;
      logic signed [35:0] r;
      d = 33'(b) - 33'(a);
      t = 51'(d) * $signed({1'b0, f}) + 51'sd32768;
      q = 35'(t >>> 16);
      r = 36'(a) + 36'(q);
      if (r > 36'sd2147483647) lerp = 32'sh7fffffff;
      else if (r < -36'sd2147483648) lerp = 32'sh80000000;
      else lerp = r[31:0];
   endfunction
endpackage

// ===== hw/rtl/tvfm_bank.sv =====
// One of eight parity banks of the field table
module tvfm_bank (
   input  logic clock,
   input  logic wr_en,
   input  logic [tvfm_pkg::AW-4:0] wr_addr,
   input  logic [95:0] wr_data,
   input  logic rd_en,
   input  logic [tvfm_pkg::AW-4:0] rd_addr,
   output logic [95:0] rd_data
);
   logic [95:0] mem [2**(tvfm_pkg::AW-3)];
   logic [95:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/tvfm_locate.sv =====
// Per-axis cell locator: offset, scale and range check over two stages
module tvfm_locate (
   input  logic clock,
   input  logic adv,
   input  logic signed [31:0] p,
   input  logic signed [31:0] origin,
   input  logic [31:0] inv,
   input  logic [8:0] size,
   output tvfm_pkg::loc_type loc
);
   logic [32:0] mag_in, mag_ff;
   logic        neg_in, neg_ff;
   logic [64:0] prod_in, prod_ff;
   logic        neg2_ff;
   logic signed [32:0] d;
   tvfm_pkg::loc_type loc_in;

   // stage A: offset magnitude
   always_comb begin
      d = 33'(p) - 33'(origin);
      neg_in = d[32];
      mag_in = d[32] ? 33'(-d) : d;
   end
   // stage B: scale
   assign prod_in = 65'(mag_ff) * 65'(inv);
   // stage C combinational: index and range
   always_comb begin
      loc_in = '0;
      if (neg2_ff) begin
         loc_in.ok = (prod_ff == '0) && (size >= 9'd2);
      end else begin
         loc_in.ok = (prod_ff[64:32] + 33'd2) <= 33'(size);
         loc_in.idx = prod_ff[39:32];
         loc_in.frac = prod_ff[31:16];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         prod_ff <= prod_in;
         neg2_ff <= neg_ff;
      end
   end
   assign loc = loc_in;
endmodule

// ===== hw/rtl/trilinear_vector_field_map_unit.sv =====
// Top level of the trilinear vector field map unit
// One transaction can enter every clock unless rsp_stall holds a result. Queries
// run through a 7-stage pipeline (offset, scale, locate, bank read, x lerp,
// y lerp, z lerp into the output register); writes give no result. All stages
// advance together; the only stall is a result held by rsp_stall, which freezes
// the whole pipe and stalls the input in the same cycle. The table sits in eight
// banks split by index parity so the eight cell corners are read together. Table
// writes travel down the pipe and land at the bank read stage, so each query sees
// exactly the writes accepted before it. Table entries are undefined until
// written; there is no clearing pass.
`include "trilinear_vector_field_map_unit_defines.svh"
module trilinear_vector_field_map_unit (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_op,
   input  logic [3:0] req_node_x,
   input  logic [3:0] req_node_y,
   input  logic [3:0] req_node_z,
   input  logic signed [31:0] req_entry_bx,
   input  logic signed [31:0] req_entry_by,
   input  logic signed [31:0] req_entry_bz,
   input  logic signed [31:0] req_px,
   input  logic signed [31:0] req_py,
   input  logic signed [31:0] req_pz,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_field_x,
   output logic signed [31:0] rsp_field_y,
   output logic signed [31:0] rsp_field_z,
   output logic rsp_in_range
);
   localparam int XW = tvfm_pkg::XW;
   localparam int YW = tvfm_pkg::YW;
   localparam int ZW = tvfm_pkg::ZW;
   localparam int BW = tvfm_pkg::AW - 3;
   localparam int NS = 7;

   logic signed [31:0] org_ff [3];
   logic [31:0] inv_ff [3];
   logic adv;
   logic [NS-1:0] vld_ff, vld_in;
   logic signed [31:0] pt [3];
   tvfm_pkg::loc_type loc [3];
   logic [8:0] sizes [3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            inv_ff[i] <= 32'd65536;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            tvfm_pkg::CSR_X_ORIGIN: org_ff[0] <= csr_wdata;
            tvfm_pkg::CSR_Y_ORIGIN: org_ff[1] <= csr_wdata;
            tvfm_pkg::CSR_Z_ORIGIN: org_ff[2] <= csr_wdata;
            tvfm_pkg::CSR_X_INV:    inv_ff[0] <= csr_wdata;
            tvfm_pkg::CSR_Y_INV:    inv_ff[1] <= csr_wdata;
            tvfm_pkg::CSR_Z_INV:    inv_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipe advances unless the output holds an untaken result
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign vld_in = {vld_ff[NS-2:0], req_valid && req_op == tvfm_pkg::OP_QUERY};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // stages 1..2: locate per axis
   assign pt[0] = req_px;
   assign pt[1] = req_py;
   assign pt[2] = req_pz;
   assign sizes[0] = 9'(tvfm_pkg::NODES_X);
   assign sizes[1] = 9'(tvfm_pkg::NODES_Y);
   assign sizes[2] = 9'(tvfm_pkg::NODES_Z);
   for (genvar a = 0; a < 3; a++) begin : g_loc
      tvfm_locate u_loc (.clock(clock), .adv(adv), .p(pt[a]), .origin(org_ff[a]),
         .inv(inv_ff[a]), .size(sizes[a]), .loc(loc[a]));
   end

   // stage 3: register location, form bank addresses
   logic ok3_ff;
   logic [7:0] ix3_ff, iy3_ff, iz3_ff;
   logic [15:0] fr3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         ok3_ff <= loc[0].ok && loc[1].ok && loc[2].ok;
         ix3_ff <= loc[0].idx;
         iy3_ff <= loc[1].idx;
         iz3_ff <= loc[2].idx;
         for (int a = 0; a < 3; a++) fr3_ff[a] <= loc[a].frac;
      end
   end

   // table writes follow the pipe so they reach the banks at the read stage
   logic wr_go;
   logic [95:0] wdat;
   logic [2:0] wv_ff;
   logic [BW-1:0] wa_ff [3];
   logic [2:0] wb_ff [3];
   logic [95:0] wd_ff [3];
   assign wr_go = req_valid && !req_stall && req_op == tvfm_pkg::OP_WRITE;
   assign wdat = {req_entry_bz, req_entry_by, req_entry_bx};
   always_ff @(posedge clock) begin
      if (reset) wv_ff <= '0;
      else if (adv) wv_ff <= {wv_ff[1:0], wr_go};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         wa_ff[0] <= {req_node_x[XW-1:1], req_node_y[YW-1:1], req_node_z[ZW-1:1]};
         wb_ff[0] <= {req_node_x[0], req_node_y[0], req_node_z[0]};
         wd_ff[0] <= wdat;
         for (int s = 1; s < 3; s++) begin
            wa_ff[s] <= wa_ff[s-1];
            wb_ff[s] <= wb_ff[s-1];
            wd_ff[s] <= wd_ff[s-1];
         end
      end
   end

   // banks: bank = {x[0],y[0],z[0]}, address = halves of indices
   logic [95:0] bdat [8];
   logic [BW-1:0] raddr [8];
   for (genvar b = 0; b < 8; b++) begin : g_bank
      localparam logic bx = b[2];
      localparam logic by = b[1];
      localparam logic bz = b[0];
      logic [XW-1:0] cx;
      logic [YW-1:0] cy;
      logic [ZW-1:0] cz;
      logic we;
      // corner coordinate on this bank's parity
      assign cx = XW'((9'(ix3_ff) + 9'(bx ^ ix3_ff[0])) >> 0);
      assign cy = YW'(9'(iy3_ff) + 9'(by ^ iy3_ff[0]));
      assign cz = ZW'(9'(iz3_ff) + 9'(bz ^ iz3_ff[0]));
      assign raddr[b] = {cx[XW-1:1], cy[YW-1:1], cz[ZW-1:1]};
      assign we = wv_ff[2] && adv && wb_ff[2] == 3'(b);
      tvfm_bank u_bank (.clock(clock), .wr_en(we), .wr_addr(wa_ff[2]),
         .wr_data(wd_ff[2]), .rd_en(adv), .rd_addr(raddr[b]), .rd_data(bdat[b]));
   end

   // stage 4: side data follows the bank read
   logic ok4_ff;
   logic [2:0] par4_ff;
   logic [15:0] fr4_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         ok4_ff <= ok3_ff;
         par4_ff <= {ix3_ff[0], iy3_ff[0], iz3_ff[0]};
         fr4_ff <= fr3_ff;
      end
   end

   // stage 5: x lerps, corner (dx,dy,dz) lives in bank parity ^ d
   tvfm_pkg::vec_type ex5_ff [4];
   logic ok5_ff;
   logic [15:0] fy5_ff, fz5_ff, fz6_ff;
   logic ok6_ff, ok7_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            for (int c = 0; c < 3; c++) begin
               ex5_ff[j][c] <= tvfm_pkg::lerp(
                  bdat[{par4_ff[2], par4_ff[1:0] ^ 2'(j)}][32*c +: 32],
                  bdat[{!par4_ff[2], par4_ff[1:0] ^ 2'(j)}][32*c +: 32], fr4_ff[0]);
            end
         end
         ok5_ff <= ok4_ff;
         fy5_ff <= fr4_ff[1];
         fz5_ff <= fr4_ff[2];
      end
   end

   // stage 6: y lerps (j = {dy,dz})
   tvfm_pkg::vec_type ey6_ff [2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 2; k++)
            for (int c = 0; c < 3; c++)
               ey6_ff[k][c] <= tvfm_pkg::lerp(ex5_ff[k][c], ex5_ff[k + 2][c], fy5_ff);
         ok6_ff <= ok5_ff;
         fz6_ff <= fz5_ff;
      end
   end

   // stage 7: z lerp and output register
   tvfm_pkg::vec_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++)
            out_ff[c] <= ok6_ff ? tvfm_pkg::lerp(ey6_ff[0][c], ey6_ff[1][c], fz6_ff) : '0;
         ok7_ff <= ok6_ff;
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_field_x = out_ff[0];
   assign rsp_field_y = out_ff[1];
   assign rsp_field_z = out_ff[2];
   assign rsp_in_range = ok7_ff;

   `TVF_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `TVF_ASSERT_IMP(a_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_field_x == '0)
   `TVF_ASSERT_IMP(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule

// ===== dv/trilinear_vector_field_map_unit_tb.sv =====
// Self-checking testbench for the trilinear vector field map unit
module trilinear_vector_field_map_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS = 1300;

   typedef struct {
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      logic        inr;
   } field_result_type;

   // predicts interpolated field vectors and checks them against the block
   class field_map_scoreboard;
      int signed   comp_tbl[3][tvfm_pkg::DEPTH];
      bit          seen[tvfm_pkg::DEPTH];
      logic signed [31:0] org[3];
      logic [31:0] inv[3];
      field_result_type pending_fields[$];
      int          errors;

      function void reset_state();
         for (int a = 0; a < tvfm_pkg::DEPTH; a++) seen[a] = 0;
         for (int i = 0; i < 3; i++) begin
            org[i] = 0;
            inv[i] = 32'd65536;
         end
         errors = 0;
      endfunction

      function void set_reg(int idx, logic [31:0] v);
         if (idx < 3) org[idx] = v;
         else inv[idx - 3] = v;
      endfunction

      function int node_addr(int x, int y, int z);
         return (x * tvfm_pkg::NODES_Y + y) * tvfm_pkg::NODES_Z + z;
      endfunction

      // cell index and Q0.16 fraction on one axis; 0 when outside the grid
      function bit find_cell(int axis, logic [31:0] p, output int idx, output int frac);
         longint d;
         longint mag;
         longint unsigned prod;
         longint unsigned ip;
         int size;
         size = (axis == 0) ? tvfm_pkg::NODES_X :
                (axis == 1) ? tvfm_pkg::NODES_Y : tvfm_pkg::NODES_Z;
         idx = 0;
         frac = 0;
         d = longint'($signed(p)) - longint'(org[axis]);
         mag = (d < 0) ? -d : d;
         prod = longint'(mag) * longint'({32'd0, inv[axis]});
         if (d < 0) return (prod == 0) && (size >= 2);
         ip = prod >> 32;
         if (ip + 2 > longint'(size)) return 0;
         idx = int'(ip);
         frac = int'((prod >> 16) & 64'hFFFF);
         return 1;
      endfunction

      function int signed blend(int signed a, int signed b, int frac);
         longint t;
         longint r;
         t = (longint'(b) - longint'(a)) * longint'(frac) + 32768;
         r = longint'(a) + (t >>> 16);
         if (r > 64'sd2147483647) return 32'sh7fffffff;
         if (r < -64'sd2147483648) return 32'sh80000000;
         return int'(r);
      endfunction

      function void note(logic op, logic [3:0] nx, logic [3:0] ny, logic [3:0] nz,
                         logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                         logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         int ix, iy, iz, fx, fy, fz, a;
         int signed ex[2][2];
         int signed ey[2];
         int signed v[3];
         field_result_type res;
         if (op == tvfm_pkg::OP_WRITE) begin
            a = node_addr(nx, ny, nz);
            comp_tbl[0][a] = bx;
            comp_tbl[1][a] = by;
            comp_tbl[2][a] = bz;
            seen[a] = 1;
            return;
         end
         res = '{0, 0, 0, 1'b0};
         if (find_cell(0, px, ix, fx) && find_cell(1, py, iy, fy) &&
             find_cell(2, pz, iz, fz)) begin
            for (int c = 0; c < 3; c++) begin
               for (int j = 0; j < 2; j++)
                  for (int k = 0; k < 2; k++)
                     ex[j][k] = blend(comp_tbl[c][node_addr(ix, iy + j, iz + k)],
                                      comp_tbl[c][node_addr(ix + 1, iy + j, iz + k)], fx);
               ey[0] = blend(ex[0][0], ex[1][0], fy);
               ey[1] = blend(ex[0][1], ex[1][1], fy);
               v[c] = blend(ey[0], ey[1], fz);
            end
            res = '{v[0], v[1], v[2], 1'b1};
         end
         pending_fields.insert(pending_fields.size(), res);
      endfunction

      function void check(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz, logic inr);
         field_result_type e;
         if (pending_fields.size() == 0) begin
            $display("%0t: result with none expected: %h %h %h %b", $time, fx, fy, fz, inr);
            errors++;
            return;
         end
         e = pending_fields.pop_front();
         if (fx !== e.fx) begin
            $display("%0t: field_x expected %h actual %h", $time, e.fx, fx);
            errors++;
         end
         if (fy !== e.fy) begin
            $display("%0t: field_y expected %h actual %h", $time, e.fy, fy);
            errors++;
         end
         if (fz !== e.fz) begin
            $display("%0t: field_z expected %h actual %h", $time, e.fz, fz);
            errors++;
         end
         if (inr !== e.inr) begin
            $display("%0t: in_range expected %b actual %b", $time, e.inr, inr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = tvfm_pkg::OP_WRITE;
   logic [3:0] req_node_x = '0, req_node_y = '0, req_node_z = '0;
   logic signed [31:0] req_entry_bx = '0, req_entry_by = '0, req_entry_bz = '0;
   logic signed [31:0] req_px = '0, req_py = '0, req_pz = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic rsp_in_range;

   field_map_scoreboard sb;
   int cycles = 0;
   bit quiet = 0;
   int rsp_hold = 0;
   int sent = 0;

   trilinear_vector_field_map_unit i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random stall pattern, mostly short
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall = 1'b1;
      end else if (quiet || $urandom_range(0, 9) < 7) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 2);
         rsp_stall = 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check(rsp_field_x, rsp_field_y, rsp_field_z, rsp_in_range);
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[trilinear_vector_field_map_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] rand_extreme();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic idle_gap();
      int gap;
      if (quiet || $urandom_range(0, 9) < 6) return;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      req_valid = 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   // one input transaction, held until accepted
   task automatic send(logic op, logic [3:0] nx, logic [3:0] ny, logic [3:0] nz,
                       logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                       logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      idle_gap();
      req_op = op;
      req_node_x = nx;
      req_node_y = ny;
      req_node_z = nz;
      req_entry_bx = bx;
      req_entry_by = by;
      req_entry_bz = bz;
      req_px = px;
      req_py = py;
      req_pz = pz;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note(op, nx, ny, nz, bx, by, bz, px, py, pz);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_node(int x, int y, int z, bit wild);
      logic [31:0] v[3];
      for (int c = 0; c < 3; c++)
         v[c] = wild ? rand_extreme() : $urandom_range(0, 32'h0fffffff) - 32'h08000000;
      send(tvfm_pkg::OP_WRITE, 4'(x), 4'(y), 4'(z), v[0], v[1], v[2],
           $urandom(), $urandom(), $urandom());
   endtask

   // query; writes any unwritten corner of the cell first
   task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      int ix, iy, iz, f;
      if (sb.find_cell(0, px, ix, f) && sb.find_cell(1, py, iy, f) &&
          sb.find_cell(2, pz, iz, f))
         for (int n = 0; n < 8; n++)
            if (!sb.seen[sb.node_addr(ix + n[0], iy + n[1], iz + n[2])])
               write_node(ix + n[0], iy + n[1], iz + n[2], $urandom_range(0, 4) == 0);
      send(tvfm_pkg::OP_QUERY, 4'($urandom()), 4'($urandom()), 4'($urandom()),
           $urandom(), $urandom(), $urandom(), px, py, pz);
   endtask

   // point near the grid on one axis: -1 to 17 node spacings past the origin
   function automatic logic [31:0] near_point(int axis);
      longint u;
      if (sb.inv[axis] == 0) return $urandom();
      u = longint'($urandom_range(0, 18 * 65536)) - 65536;
      if ($urandom_range(0, 7) == 0) u = longint'($urandom_range(0, 16)) * 65536;
      return 32'(longint'(sb.org[axis]) + (u * 65536) / longint'({32'd0, sb.inv[axis]}));
   endfunction

   task automatic write_reg(tvfm_pkg::csr_index_type idx, logic [31:0] v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_reg(int'(idx), v);
   endtask

   task automatic drain();
      int waited;
      req_valid = 1'b0;
      waited = 0;
      while (sb.pending_fields.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [31:0] ov[3];
      logic [31:0] iv;
      sb = new();
      sb.reset_state();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: corner values, cell edges, below origin, past grid
      write_node(0, 0, 0, 0);
      send(tvfm_pkg::OP_WRITE, 4'hf, 4'hf, 4'hf, 32'h7fffffff, 32'h80000000, 32'h0,
           32'hffffffff, 32'h0, 32'h0);
      send(tvfm_pkg::OP_WRITE, 4'he, 4'hf, 4'hf, 32'h80000000, 32'h7fffffff, 32'hffffffff,
           32'h0, 32'hffffffff, 32'h0);
      query(32'h0, 32'h0, 32'h0);
      query(32'h000e_ffff, 32'h000e_ffff, 32'h000e_ffff);
      query(32'h000e_8000, 32'h000e_0000, 32'h000e_0001);
      query(32'h000f_0000, 32'h0, 32'h0);
      query(32'h0, 32'h0, 32'h000f_0000);
      query(32'hffffffff, 32'h0, 32'h0);
      query(32'h0, 32'h80000000, 32'h0);
      query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      query(32'h0000_7fff, 32'h0001_8000, 32'h0002_c000);

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         quiet = (ph == 2);
         // register settings: extremes first, then moderate random grids
         for (int i = 0; i < 3; i++) begin
            case (ph)
               0: begin ov[i] = 32'h80000000; iv = 32'h0000_0001; end
               1: begin ov[i] = 32'h7fffffff; iv = 32'hffffffff; end
               2: begin ov[i] = 32'h0; iv = 32'h0; end
               3: begin ov[i] = 32'hfff0_0000; iv = 32'h0000_4000; end
               default: begin
                  ov[i] = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
                  iv = $urandom_range(32'h0000_2000, 32'h0008_0000);
               end
            endcase
            write_reg(tvfm_pkg::csr_index_type'(tvfm_pkg::CSR_X_ORIGIN + i), ov[i]);
            write_reg(tvfm_pkg::csr_index_type'(tvfm_pkg::CSR_X_INV + i), iv);
         end
         while (sent < (ph + 1) * ITEMS / 7) begin
            case ($urandom_range(0, 9))
               0: write_node($urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 15), 1);
               1: query(rand_extreme(), rand_extreme(), rand_extreme());
               default: query(near_point(0), near_point(1), near_point(2));
            endcase
         end
      end
      drain();

      if (sb.errors == 0 && sb.pending_fields.size() == 0) begin
         $display("[trilinear_vector_field_map_unit] OK");
      end else begin
         $display("[trilinear_vector_field_map_unit] ERROR");
      end
      $finish;
   end
endmodule
